// File: hdl/rcdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcdf_pkg: recent command duplicate filter package
// Field widths and the window reset value shared by the filter.
// ----------------------------------------------------------------------------
package rcdf_pkg;

  localparam int unsigned SEQ_W  = 8;
  localparam int unsigned CMD_W  = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned WIN_W  = 16;

  localparam logic [WIN_W-1:0] WIN_RESET = 16'd1000;

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [WIN_W-1:0]  win_t;

endpackage : rcdf_pkg
`default_nettype wire

// File: hdl/recent_command_duplicate_filter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// recent_command_duplicate_filter_unit: recent command duplicate filter
// Flags a received command as a duplicate when a recent table entry holds
// the same sequence and command within the configured window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per received
//   frame: seq_number_i, command_code_i, now_ms_i. Output channel
//   (out_valid_o / out_stall_i) returns one word per input: is_duplicate_o.
//   A word is taken on a rising edge with valid high and stall low.
//   A taken word moves from the input register to the result register,
//   which drives the output; one word per cycle is sustained while
//   out_stall_i stays low. The table search and update run between the
//   input register and the result register, so each word sees the table
//   left by the word before it.
//   A new word is taken while a finished result still waits; when the
//   receiver stalls and both registers are full, in_stall_o rises.
//   Reset clears all table entries, both pipeline registers and sets the
//   window to 1000 ms. cfg_we_i / cfg_wdata_i write the window; write it
//   only while no word is in flight.
// ----------------------------------------------------------------------------
module recent_command_duplicate_filter_unit #(
  parameter int unsigned ENTRIES = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire rcdf_pkg::win_t  cfg_wdata_i,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire rcdf_pkg::seq_t  seq_number_i,
  input  wire rcdf_pkg::cmd_t  command_code_i,
  input  wire rcdf_pkg::time_t now_ms_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic                 is_duplicate_o
);

  import rcdf_pkg::*;

  win_t                 win_q;
  logic                 in_vld_q;
  seq_t                 in_seq_q;
  cmd_t                 in_cmd_q;
  time_t                in_time_q;
  logic                 out_vld_q;
  logic                 dup_q;
  logic [ENTRIES-1:0]   slot_vld_q;
  seq_t                 slot_seq_q  [ENTRIES];
  cmd_t                 slot_cmd_q  [ENTRIES];
  time_t                slot_time_q [ENTRIES];

  logic                 advance;
  logic                 in_take;
  logic [ENTRIES-1:0]   hit;
  logic                 dup_d;
  logic                 full;
  logic [ENTRIES-1:0]   wr_sel;
  logic                 upd;
  time_t                age [ENTRIES];

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_stall_o = in_vld_q && !advance;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      age[i] = in_time_q - slot_time_q[i];
      hit[i] = slot_vld_q[i] && (slot_seq_q[i] == in_seq_q) &&
               (slot_cmd_q[i] == in_cmd_q) &&
               (age[i][TIME_W-1:WIN_W] == '0) && (age[i][WIN_W-1:0] <= win_q);
    end
  end

  assign dup_d = |hit;
  assign full  = slot_vld_q[ENTRIES-1];
  assign upd   = advance && !dup_d;

  // valid bits fill as a prefix, so the lowest free entry follows the last valid one
  always_comb begin
    wr_sel[0] = !slot_vld_q[0];
    for (int i = 1; i < ENTRIES; i++) begin
      wr_sel[i] = !slot_vld_q[i] && slot_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= WIN_RESET;
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      slot_vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (upd) begin
        slot_vld_q <= full ? slot_vld_q : (slot_vld_q | wr_sel);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_seq_q  <= seq_number_i;
      in_cmd_q  <= command_code_i;
      in_time_q <= now_ms_i;
    end
    if (advance) begin
      dup_q <= dup_d;
    end
    if (upd) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (full) begin
          if (i < ENTRIES - 1) begin
            slot_seq_q[i]  <= slot_seq_q[i+1];
            slot_cmd_q[i]  <= slot_cmd_q[i+1];
            slot_time_q[i] <= slot_time_q[i+1];
          end else begin
            slot_seq_q[i]  <= in_seq_q;
            slot_cmd_q[i]  <= in_cmd_q;
            slot_time_q[i] <= in_time_q;
          end
        end else if (wr_sel[i]) begin
          slot_seq_q[i]  <= in_seq_q;
          slot_cmd_q[i]  <= in_cmd_q;
          slot_time_q[i] <= in_time_q;
        end
      end
    end
  end

  assign out_valid_o    = out_vld_q;
  assign is_duplicate_o = dup_q;

  a_new_word_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !dup_d) |=> slot_vld_q[0])
    else $error("new word left the table empty");

  a_dup_keeps_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && dup_d) |=> $stable(slot_vld_q))
    else $error("duplicate word changed the table");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((slot_vld_q & (slot_vld_q + ENTRIES'(1))) == '0))
    else $error("table valid bits are not contiguous");

  a_dup_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && dup_d) |-> (slot_vld_q != '0))
    else $error("duplicate flagged with an empty table");

endmodule : recent_command_duplicate_filter_unit
`default_nettype wire

// File: dv/recent_command_duplicate_filter_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// recent_command_duplicate_filter_unit_test: duplicate filter regression
// Sends command frames through the filter with random idle and stall on both
// channels. A local copy of the recent-command table predicts is_duplicate
// for every accepted word, and each returned word is checked against it.
// A directed opener covers window boundaries, time wrap and table eviction.
// Random phases then sweep the window setting, including both extremes.
// ----------------------------------------------------------------------------
module recent_command_duplicate_filter_unit_test;
  import rcdf_pkg::*;

  localparam int ENTRIES   = 8;
  localparam int LONG_HOLD = 120;
  localparam int LIMIT     = 400000;

  typedef struct packed {
    seq_t  seq;
    cmd_t  cmd;
    time_t stamp;
  } frame_t;

  logic  clk          = 1'b0;
  logic  rst_n        = 1'b0;
  logic  cfg_we       = 1'b0;
  win_t  cfg_wdata    = '0;
  logic  in_valid     = 1'b0;
  logic  in_stall;
  seq_t  seq_number   = '0;
  cmd_t  command_code = '0;
  time_t now_ms       = '0;
  logic  out_valid;
  logic  out_stall    = 1'b0;
  logic  is_duplicate;

  recent_command_duplicate_filter_unit #(.ENTRIES(ENTRIES)) u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .seq_number_i  (seq_number),
    .command_code_i(command_code),
    .now_ms_i      (now_ms),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .is_duplicate_o(is_duplicate)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // local copy of the filter state
  win_t  win_model = WIN_RESET;
  bit    tbl_valid [ENTRIES];
  seq_t  tbl_seq   [ENTRIES];
  cmd_t  tbl_cmd   [ENTRIES];
  time_t tbl_time  [ENTRIES];

  frame_t pending[$];
  frame_t recent_sent[$];
  bit     expected_dup[$];
  time_t  t_clock = '0;

  int tx_gap_max = 14;
  int rx_gap_max = 14;
  int tx_wait    = 0;
  int rx_wait    = 0;
  int n_results  = 0;
  int n_errors   = 0;
  int n_cycles   = 0;
  frame_t tx_word;
  bit     exp_dup;

  function automatic bit predict_duplicate(seq_t s, cmd_t c, time_t t);
    bit    hit;
    bit    placed;
    time_t age;
    hit = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      age = t - tbl_time[i];
      if (tbl_valid[i] && tbl_seq[i] == s && tbl_cmd[i] == c && age <= time_t'(win_model))
        hit = 1'b1;
    end
    if (hit) return 1'b1;
    placed = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!placed && !tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_seq[i]   = s;
        tbl_cmd[i]   = c;
        tbl_time[i]  = t;
        placed       = 1'b1;
      end
    end
    if (!placed) begin
      for (int i = 1; i < ENTRIES; i++) begin
        tbl_valid[i-1] = tbl_valid[i];
        tbl_seq[i-1]   = tbl_seq[i];
        tbl_cmd[i-1]   = tbl_cmd[i];
        tbl_time[i-1]  = tbl_time[i];
      end
      tbl_valid[ENTRIES-1] = 1'b1;
      tbl_seq[ENTRIES-1]   = s;
      tbl_cmd[ENTRIES-1]   = c;
      tbl_time[ENTRIES-1]  = t;
    end
    return 1'b0;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_dup.push_back(predict_duplicate(seq_number, command_code, now_ms));
        tx_wait = $urandom_range(0, tx_gap_max);
      end else if (!in_valid && tx_wait != 0) begin
        tx_wait = tx_wait - 1;
      end
      if ((!in_valid || !in_stall) && tx_wait == 0 && pending.size() != 0) begin
        tx_word = pending.pop_front();
        seq_number   <= tx_word.seq;
        command_code <= tx_word.cmd;
        now_ms       <= tx_word.stamp;
        in_valid     <= 1'b1;
      end else if (!in_valid || !in_stall) begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver and checker; every 250th word is followed by a long hold
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results = n_results + 1;
        if (expected_dup.size() == 0) begin
          n_errors = n_errors + 1;
          if (n_errors <= 10)
            $display("word %0d: unexpected, is_duplicate=%0b", n_results, is_duplicate);
        end else begin
          exp_dup = expected_dup.pop_front();
          if (is_duplicate !== exp_dup) begin
            n_errors = n_errors + 1;
            if (n_errors <= 10)
              $display("word %0d: is_duplicate expected %0b, got %0b",
                       n_results, exp_dup, is_duplicate);
          end
        end
        rx_wait = (n_results % 250 == 0) ? LONG_HOLD : $urandom_range(0, rx_gap_max);
      end else if (rx_wait != 0) begin
        rx_wait = rx_wait - 1;
      end
      out_stall <= (rx_wait != 0);
    end
  end

  always @(posedge clk) begin
    n_cycles = n_cycles + 1;
    if (n_cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_frame(seq_t s, cmd_t c, time_t t);
    frame_t f;
    f.seq   = s;
    f.cmd   = c;
    f.stamp = t;
    pending.push_back(f);
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || in_valid || expected_dup.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_window(win_t w);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    win_model = w;
    @(negedge clk);
  endtask

  // mostly repeats of recent frames with plausible time steps, some noise
  task automatic queue_random_frames(int count);
    frame_t f;
    int     k;
    int     r;
    bit     reuse;
    repeat (count) begin
      reuse = 1'b0;
      k     = 0;
      r     = $urandom_range(0, 99);
      if (r < 60 && recent_sent.size() != 0) begin
        k     = $urandom_range(0, recent_sent.size() - 1);
        f.seq = recent_sent[k].seq;
        f.cmd = recent_sent[k].cmd;
        reuse = 1'b1;
      end else if (r < 75) begin
        f.seq = seq_t'($urandom_range(0, 3));
        f.cmd = cmd_t'($urandom_range(0, 3));
      end else begin
        f.seq = seq_t'($urandom_range(0, 255));
        f.cmd = cmd_t'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 99);
      if (r < 4)
        t_clock = $urandom();
      else if (r < 8)
        t_clock = t_clock - $urandom_range(1, 50);
      else if (r < 25 && reuse)
        t_clock = recent_sent[k].stamp + win_model + $urandom_range(0, 1);
      else
        t_clock = t_clock + $urandom_range(0, win_model / 3 + 2);
      f.stamp = t_clock;
      pending.push_back(f);
      recent_sent.push_back(f);
      if (recent_sent.size() > 12) void'(recent_sent.pop_front());
    end
  endtask

  initial begin
    win_t windows [6];
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset window: boundary, stale repeat, wrap, backwards time, eviction
    push_frame(8'h00, 8'h00, 32'd0);
    push_frame(8'h00, 8'h00, 32'd1000);
    push_frame(8'h00, 8'h00, 32'd1001);
    push_frame(8'hFF, 8'hFF, 32'hFFFF_FFFF);
    push_frame(8'hFF, 8'hFF, 32'h0000_03E7);
    push_frame(8'hFF, 8'hFF, 32'hFFFF_FFFE);
    push_frame(8'h00, 8'hFF, 32'd5);
    push_frame(8'hFF, 8'h00, 32'd5);
    push_frame(8'hA5, 8'h5A, 32'd10);
    push_frame(8'h5A, 8'hA5, 32'd11);
    push_frame(8'h3C, 8'hC3, 32'd12);
    push_frame(8'h00, 8'h00, 32'd1000);

    set_window(16'h0000);
    push_frame(8'h10, 8'h20, 32'd777);
    push_frame(8'h10, 8'h20, 32'd777);
    push_frame(8'h10, 8'h20, 32'd778);

    set_window(16'hFFFF);
    push_frame(8'h10, 8'h20, 32'd66313);
    push_frame(8'h10, 8'h20, 32'd66314);
    push_frame(8'h10, 8'h20, 32'd66314);
    push_frame(8'h80, 8'h01, 32'h8000_0000);

    windows[0] = 16'd1000;
    windows[1] = 16'd0;
    windows[2] = 16'hFFFF;
    windows[3] = 16'd1;
    windows[4] = win_t'($urandom_range(2, 65534));
    windows[5] = 16'd300;
    for (int p = 0; p < 6; p++) begin
      set_window(windows[p]);
      tx_gap_max = (p == 1 || p == 4) ? 0 : 14;
      rx_gap_max = (p == 1 || p == 4) ? 0 : 14;
      if (p == 2) t_clock = 32'hFFFF_F000;
      recent_sent.delete();
      queue_random_frames(155);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (n_errors == 0 && expected_dup.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
